// File: design/tms_pkg.sv
package tms_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    localparam int TIMER_CLOCK_HZ   = 1000000;
    localparam int MELODY_W         = 3;
    localparam int STEP_W           = 3;
    localparam int COUNT_W          = 9;
    localparam int RELOAD_W         = 10;
    localparam int COMPARE_W        = 9;
    localparam int NOTE_ADDR_W      = MELODY_W + STEP_W;
    localparam logic [MELODY_W-1:0] ROM_MELODIES = MELODY_W'(5);

    localparam int RELOAD_MAX  = (1 << RELOAD_W) - 1;
    localparam int COMPARE_MAX = (1 << COMPARE_W) - 1;

    // Input word widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    // Output word width: tone_on, reload, compare, tone_loaded, playing, padded
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic                  ok;      // step lies inside the melody
        logic                  rest;
        logic [RELOAD_W-1:0]   reload;
        logic [COMPARE_W-1:0]  compare;
        logic [COUNT_W-1:0]    dur;
    } t_note;

    // Timer counts per period are given per note; reload and compare follow.
    function automatic t_note mk_tone(input int counts, input int dur);
        t_note n;
        int    rel;
        int    cmp;
        rel = (counts > 0) ? counts - 1 : 0;
        cmp = counts / 2;
        n.ok      = 1'b1;
        n.rest    = 1'b0;
        n.reload  = (rel > RELOAD_MAX) ? RELOAD_W'(RELOAD_MAX) : RELOAD_W'(rel);
        n.compare = (cmp > COMPARE_MAX) ? COMPARE_W'(COMPARE_MAX) : COMPARE_W'(cmp);
        n.dur     = COUNT_W'(dur);
        return n;
    endfunction

    function automatic t_note mk_rest(input int dur);
        t_note n;
        n         = '0;
        n.ok      = 1'b1;
        n.rest    = 1'b1;
        n.dur     = COUNT_W'(dur);
        return n;
    endfunction

    // Note table, indexed by {melody, step}; entries past a melody's end are not ok
    function automatic t_note note_rom(input logic [NOTE_ADDR_W-1:0] addr);
        t_note n;
        n = '0;
        case (addr)
            // power-on
            6'o00: n = mk_tone(TIMER_CLOCK_HZ / 1000, 100);
            6'o01: n = mk_tone(TIMER_CLOCK_HZ / 2000, 100);
            6'o02: n = mk_tone(TIMER_CLOCK_HZ / 3000, 200);
            6'o03: n = mk_tone(TIMER_CLOCK_HZ / 1000, 50);
            // short
            6'o10: n = mk_tone(TIMER_CLOCK_HZ / 4000, 100);
            6'o11: n = mk_rest(50);
            // double
            6'o20: n = mk_tone(TIMER_CLOCK_HZ / 2000, 300);
            6'o21: n = mk_rest(100);
            6'o22: n = mk_tone(TIMER_CLOCK_HZ / 4000, 200);
            6'o23: n = mk_rest(100);
            6'o24: n = mk_tone(TIMER_CLOCK_HZ / 4000, 400);
            // error
            6'o30: n = mk_tone(TIMER_CLOCK_HZ / 4000, 100);
            6'o31: n = mk_tone(TIMER_CLOCK_HZ / 3000, 100);
            6'o32: n = mk_tone(TIMER_CLOCK_HZ / 2000, 100);
            6'o33: n = mk_tone(TIMER_CLOCK_HZ / 1000, 200);
            // success
            6'o40: n = mk_tone(TIMER_CLOCK_HZ / 4000, 100);
            6'o41: n = mk_rest(50);
            6'o42: n = mk_tone(TIMER_CLOCK_HZ / 4000, 100);
            6'o43: n = mk_tone(TIMER_CLOCK_HZ / 5000, 150);
            6'o44: n = mk_tone(TIMER_CLOCK_HZ / 4000, 200);
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

// File: design/tone_melody_sequencer.sv
// Channel  | Dir | Word layout (lowest bit first)
// s_axis   | in  | tuser[1:0] req_type; tdata[2:0] melody_id
// m_axis   | out | tdata: tone_on, reload_value[9:0], compare_value[8:0],
//          |     |        tone_loaded, playing, two zero bits
//
// One word is taken per cycle while s_tready is high, and its result word is registered in the output buffer.
// The note table is a synchronous ROM addressed by the next sequencer state, so
// the entry for the current melody step already sits in its output register.
// Reset is synchronous and clears the sequencer and the output buffer at once.
// A two-word output buffer takes input while one result waits; s_tready
// falls only when both slots are full.
module tone_melody_sequencer
    import tms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // melody_id[2:0], zero pad
    input  logic [S_TUSER_W-1:0]  i_s_tuser,   // req_type[1:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata    // tone_on, reload_value[9:0],
                                               // compare_value[8:0], tone_loaded,
                                               // playing, zero pad
);

    // Sequencer state
    logic                  r_active,  n_active;
    logic [MELODY_W-1:0]   r_melody,  n_melody;
    logic [STEP_W-1:0]     r_step,    n_step;
    logic [COUNT_W-1:0]    r_count,   n_count;
    logic                  r_tone,    n_tone;
    logic [RELOAD_W-1:0]   r_period,  n_period;
    logic [COMPARE_W-1:0]  r_cmp,     n_cmp;
    logic                  loaded;

    // ROM output register: note at {r_melody, r_step}
    t_note                 r_note;
    logic [NOTE_ADDR_W-1:0] rom_addr;

    // Output buffer
    logic [M_TDATA_W-1:0]  r_q0, r_q1;
    logic [1:0]            r_qcnt;
    logic                  push, pop;
    logic [M_TDATA_W-1:0]  new_word;
    logic [COUNT_W-1:0]    cnt_inc;

    assign o_s_tready = (r_qcnt != 2'd2);
    assign o_m_tvalid = (r_qcnt != 2'd0);
    assign o_m_tdata  = r_q0;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = o_m_tvalid && i_m_tready;
    assign cnt_inc    = r_count + COUNT_W'(1);

    always_comb begin
        n_active = r_active;
        n_melody = r_melody;
        n_step   = r_step;
        n_count  = r_count;
        n_tone   = r_tone;
        n_period = r_period;
        n_cmp    = r_cmp;
        loaded   = 1'b0;
        if (push) begin
            unique case (i_s_tuser)
                REQ_TICK: begin
                    if (r_active) begin
                        priority if (r_melody >= ROM_MELODIES) begin
                            // unknown melody: drop playback, leave the tone
                            n_active = 1'b0;
                        end else if (!r_note.ok) begin
                            // ran past the last note
                            n_tone   = 1'b0;
                            n_active = 1'b0;
                            n_step   = '0;
                            n_count  = '0;
                        end else begin
                            n_count = cnt_inc;
                            if (cnt_inc == COUNT_W'(1)) begin
                                loaded = 1'b1;
                                if (r_note.rest) begin
                                    n_tone = 1'b0;
                                end else begin
                                    n_tone   = 1'b1;
                                    n_period = r_note.reload;
                                    n_cmp    = r_note.compare;
                                end
                            end
                            if (cnt_inc >= r_note.dur) begin
                                n_step  = r_step + STEP_W'(1);
                                n_count = '0;
                            end
                        end
                    end
                end
                REQ_START: begin
                    if (r_active) begin
                        n_tone = 1'b0;
                    end
                    n_melody = i_s_tdata[MELODY_W-1:0];
                    n_step   = '0;
                    n_count  = '0;
                    n_active = 1'b1;
                end
                REQ_STOP: begin
                    n_tone   = 1'b0;
                    n_active = 1'b0;
                    n_step   = '0;
                    n_count  = '0;
                end
                default: begin
                    // unused request code: no change
                end
            endcase
        end
    end

    assign new_word = {2'b00, n_active, loaded, n_cmp, n_period, n_tone};
    assign rom_addr = i_rst_n ? {n_melody, n_step} : '0;

    // Note ROM, registered read
    always_ff @(posedge i_clk) begin
        r_note <= note_rom(rom_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_melody <= '0;
            r_step   <= '0;
            r_count  <= '0;
            r_tone   <= 1'b0;
            r_period <= '0;
            r_cmp    <= '0;
        end else begin
            r_active <= n_active;
            r_melody <= n_melody;
            r_step   <= n_step;
            r_count  <= n_count;
            r_tone   <= n_tone;
            r_period <= n_period;
            r_cmp    <= n_cmp;
        end
    end

    // Output buffer: head in r_q0, second word in r_q1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10:   r_qcnt <= r_qcnt + 2'd1;
                2'b01:   r_qcnt <= r_qcnt - 2'd1;
                default: r_qcnt <= r_qcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case ({push, pop})
            2'b11: begin
                if (r_qcnt == 2'd1) begin
                    r_q0 <= new_word;
                end else begin
                    r_q0 <= r_q1;
                    r_q1 <= new_word;
                end
            end
            2'b10: begin
                if (r_qcnt == 2'd0) begin
                    r_q0 <= new_word;
                end else begin
                    r_q1 <= new_word;
                end
            end
            2'b01: r_q0 <= r_q1;
            default: begin
                // hold
            end
        endcase
    end

endmodule

// File: design/tms_checker.sv
module tms_checker
    import tms_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [S_TUSER_W-1:0]  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_TDATA_W-1:0]  o_m_tdata
);

    // Buffer empties on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output word changed");

    // Stop into an empty buffer gives a silent, idle word next cycle
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid && i_s_tuser == REQ_STOP
        |=> o_m_tvalid && !o_m_tdata[0] && !o_m_tdata[21] && !o_m_tdata[20])
        else $error("stop did not silence playback");

    // Start into an empty buffer reports playing without a load
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid && i_s_tuser == REQ_START
        |=> o_m_tvalid && o_m_tdata[21] && !o_m_tdata[20])
        else $error("start did not begin playback");

    // A tone load happens only during playback
    a_load_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[20] |-> o_m_tdata[21])
        else $error("tone loaded while not playing");

endmodule

bind tone_melody_sequencer tms_checker u_tms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: bench/tone_melody_sequencer_tb.sv
`timescale 1ns / 1ps

module tone_melody_sequencer_tb;
    import tms_pkg::*;

    // Request code with no meaning to the sequencer
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Melody numbers
    localparam logic [MELODY_W-1:0] TUNE_POWER_ON = 3'd0;
    localparam logic [MELODY_W-1:0] TUNE_SHORT    = 3'd1;
    localparam logic [MELODY_W-1:0] TUNE_DOUBLE   = 3'd2;
    localparam logic [MELODY_W-1:0] TUNE_ERROR    = 3'd3;
    localparam logic [MELODY_W-1:0] TUNE_SUCCESS  = 3'd4;
    localparam logic [MELODY_W-1:0] TUNE_BAD_LO   = 3'd5;
    localparam logic [MELODY_W-1:0] TUNE_BAD_MID  = 3'd6;
    localparam logic [MELODY_W-1:0] TUNE_BAD_HI   = 3'd7;

    localparam int RANDOM_WORDS  = 400;
    localparam int LONG_HOLD     = 80;
    localparam int HOLD_AFTER    = 120;

    // Player state as the sequencer keeps it
    typedef struct packed {
        logic                 active;
        logic [MELODY_W-1:0]  melody;
        logic [STEP_W-1:0]    step;
        logic [COUNT_W-1:0]   ticks;
        logic                 tone;
        logic [RELOAD_W-1:0]  reload;
        logic [COMPARE_W-1:0] compare;
    } t_player;

    // Result word, first member in the highest bits, so tone_on lands at bit 0
    typedef struct packed {
        logic                 playing;
        logic                 loaded;
        logic [COMPARE_W-1:0] compare;
        logic [RELOAD_W-1:0]  reload;
        logic                 tone;
    } t_tone_word;

    typedef struct {
        logic [1:0]          req;
        logic [MELODY_W-1:0] id;
        logic                drain;   // hold until every result is back
    } t_request;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // melody_id[2:0], zero pad
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // req_type[1:0]
    logic                 o_m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;       // tone_on, reload[9:0], compare[8:0],
                                           // tone_loaded, playing, zero pad

    t_request   pending_words[$];
    t_tone_word expected_words[$];

    t_player    plan;          // state used while building the stimulus
    t_player    live;          // state advanced as words are accepted
    t_request   offer;
    logic       drain_next = 1'b0;
    logic       tx_fast    = 1'b0;
    logic       rx_fast    = 1'b0;
    int         tx_wait    = 0;
    int         rx_wait    = 0;
    int         hold_left  = 0;
    logic       hold_done  = 1'b0;
    int         n_planned  = 0;
    int         n_finished = 0;
    int         n_sent     = 0;
    int         n_loaded   = 0;
    int         n_results  = 0;
    int         n_errors   = 0;

    tone_melody_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Frequency in Hz (0 for a rest) and duration in ticks of one note
    function automatic void tune_note(input logic [MELODY_W-1:0] m,
                                      input logic [STEP_W-1:0] s,
                                      output int freq, output int dur);
        freq = 0;
        dur  = 0;
        case ({m, s})
            6'o00: begin freq = 1000; dur = 100; end
            6'o01: begin freq = 2000; dur = 100; end
            6'o02: begin freq = 3000; dur = 200; end
            6'o03: begin freq = 1000; dur = 50;  end
            6'o10: begin freq = 4000; dur = 100; end
            6'o11: begin freq = 0;    dur = 50;  end
            6'o20: begin freq = 2000; dur = 300; end
            6'o21: begin freq = 0;    dur = 100; end
            6'o22: begin freq = 4000; dur = 200; end
            6'o23: begin freq = 0;    dur = 100; end
            6'o24: begin freq = 4000; dur = 400; end
            6'o30: begin freq = 4000; dur = 100; end
            6'o31: begin freq = 3000; dur = 100; end
            6'o32: begin freq = 2000; dur = 100; end
            6'o33: begin freq = 1000; dur = 200; end
            6'o40: begin freq = 4000; dur = 100; end
            6'o41: begin freq = 0;    dur = 50;  end
            6'o42: begin freq = 4000; dur = 100; end
            6'o43: begin freq = 5000; dur = 150; end
            6'o44: begin freq = 4000; dur = 200; end
            default: ;
        endcase
    endfunction

    function automatic int tune_length(input logic [MELODY_W-1:0] m);
        case (m)
            TUNE_POWER_ON: return 4;
            TUNE_SHORT:    return 2;
            TUNE_DOUBLE:   return 5;
            TUNE_ERROR:    return 4;
            TUNE_SUCCESS:  return 5;
            default:       return 0;
        endcase
    endfunction

    // Drop the tone and rewind; timer values stay as loaded
    function automatic t_player silence(input t_player p);
        t_player q;
        q        = p;
        q.tone   = 1'b0;
        q.active = 1'b0;
        q.step   = '0;
        q.ticks  = '0;
        return q;
    endfunction

    // Advance the player by one request and form the result word
    function automatic t_tone_word play_step(input t_player cur, input logic [1:0] req,
                                             input logic [MELODY_W-1:0] id,
                                             output t_player nxt);
        t_tone_word w;
        int         freq;
        int         dur;
        int         counts;
        int         rel;
        int         cmp;
        nxt      = cur;
        w.loaded = 1'b0;
        case (req)
            REQ_TICK: begin
                if (nxt.active) begin
                    if (nxt.melody >= ROM_MELODIES) begin
                        nxt.active = 1'b0;
                    end else if (int'(nxt.step) >= tune_length(nxt.melody)) begin
                        nxt = silence(nxt);
                    end else begin
                        tune_note(nxt.melody, nxt.step, freq, dur);
                        nxt.ticks = nxt.ticks + 1'b1;
                        if (nxt.ticks == 1) begin
                            if (freq == 0) begin
                                nxt.tone = 1'b0;
                            end else begin
                                counts      = TIMER_CLOCK_HZ / freq;
                                rel         = (counts > 0) ? counts - 1 : 0;
                                cmp         = counts / 2;
                                nxt.reload  = RELOAD_W'((rel > RELOAD_MAX) ? RELOAD_MAX : rel);
                                nxt.compare = COMPARE_W'((cmp > COMPARE_MAX) ? COMPARE_MAX : cmp);
                                nxt.tone    = 1'b1;
                            end
                            w.loaded = 1'b1;
                        end
                        if (int'(nxt.ticks) >= dur) begin
                            nxt.step  = nxt.step + 1'b1;
                            nxt.ticks = '0;
                        end
                    end
                end
            end
            REQ_START: begin
                if (nxt.active)
                    nxt = silence(nxt);
                nxt.melody = id;
                nxt.step   = '0;
                nxt.ticks  = '0;
                nxt.active = 1'b1;
            end
            REQ_STOP: nxt = silence(nxt);
            default: ;
        endcase
        w.tone    = nxt.tone;
        w.reload  = nxt.reload;
        w.compare = nxt.compare;
        w.playing = nxt.active;
        return w;
    endfunction

    // Append one request word and follow it in the planning copy of the player
    task automatic queue_word(input logic [1:0] req, input logic [MELODY_W-1:0] id);
        t_request   r;
        t_player    nxt;
        t_tone_word w;
        w = play_step(plan, req, id, nxt);
        if (plan.active && !nxt.active && req == REQ_TICK && plan.melody < ROM_MELODIES)
            n_finished++;
        plan    = nxt;
        r.req   = req;
        r.id    = id;
        r.drain = drain_next;
        drain_next = 1'b0;
        pending_words.push_back(r);
        n_planned++;
    endtask

    task automatic queue_ticks(input int count);
        for (int k = 0; k < count; k++) begin
            // sprinkle ignored codes into the tick stream
            if ($urandom_range(0, 24) == 0)
                queue_word(REQ_UNUSED, MELODY_W'($urandom_range(0, 7)));
            queue_word(REQ_TICK, MELODY_W'($urandom_range(0, 7)));
        end
    endtask

    task check_field(input string label, input int want, input int got);
        if (want != got) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Sender: offer the next pending word, then idle a drawn number of cycles
    always @(posedge i_clk) begin : drive_words
        int         gap;
        t_player    after;
        t_tone_word want;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                want = play_step(live, offer.req, offer.id, after);
                live = after;
                expected_words.push_back(want);
                n_sent++;
                if (want.loaded)
                    n_loaded++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait  <= tx_wait - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() == 0 ||
                             (pending_words[0].drain && expected_words.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    offer = pending_words.pop_front();
                    if ($urandom_range(0, 31) == 0)
                        tx_fast = ~tx_fast;
                    gap      = tx_fast ? 0 : $urandom_range(0, 15);
                    tx_wait  <= gap;
                    s_tvalid <= 1'b1;
                    s_tuser  <= offer.req;
                    s_tdata  <= S_TDATA_W'(offer.id);
                end
            end
        end
    end

    // Receiver: check each result word against the oldest expectation
    always @(posedge i_clk) begin : watch_words
        int         gap;
        t_tone_word want;
        t_tone_word got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                got = o_m_tdata[$bits(t_tone_word)-1:0];
                if (expected_words.size() == 0) begin
                    n_errors++;
                    $display("%0t ns: unexpected result word, expected none, actual %h",
                             $time, o_m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    check_field("tone_on", want.tone, got.tone);
                    check_field("reload_value", want.reload, got.reload);
                    check_field("compare_value", want.compare, got.compare);
                    check_field("tone_loaded", want.loaded, got.loaded);
                    check_field("playing", want.playing, got.playing);
                end
                n_results++;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= (hold_left == 1);
            end else if (!hold_done && n_results >= HOLD_AFTER) begin
                // long hold-off: let the output buffer fill and stall the input side
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                m_tready  <= 1'b0;
            end else if (o_m_tvalid && m_tready) begin
                if ($urandom_range(0, 31) == 0)
                    rx_fast = ~rx_fast;
                gap      = rx_fast ? 0 : $urandom_range(0, 15);
                rx_wait  <= gap;
                m_tready <= (gap == 0);
            end else if (rx_wait > 0) begin
                rx_wait  <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : run_test
        int pick;
        int m;
        plan = '0;
        live = '0;

        // Directed: idle requests, invalid melodies, restarts and the first note of each valid melody
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_UNUSED, TUNE_BAD_HI);
        queue_word(REQ_STOP, TUNE_POWER_ON);
        queue_word(REQ_START, TUNE_BAD_LO);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_START, TUNE_BAD_HI);
        queue_word(REQ_TICK, TUNE_BAD_MID);
        queue_word(REQ_START, TUNE_POWER_ON);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_UNUSED, TUNE_SHORT);
        queue_word(REQ_START, TUNE_DOUBLE);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_STOP, TUNE_POWER_ON);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_START, TUNE_SHORT);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_START, TUNE_ERROR);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_STOP, TUNE_BAD_HI);
        queue_word(REQ_START, TUNE_SUCCESS);
        queue_word(REQ_TICK, TUNE_POWER_ON);
        queue_word(REQ_START, TUNE_BAD_MID);

        // Directed: play the short melody to its end, twice in a row
        repeat (2) begin
            queue_word(REQ_START, TUNE_SHORT);
            while (plan.active)
                queue_ticks(1);
        end

        // Random: mostly melodies started and ticked along, some run to their end
        drain_next = 1'b1;
        while (n_planned < RANDOM_WORDS || n_finished < 2) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                m = ($urandom_range(0, 2) != 0) ? TUNE_SHORT : $urandom_range(0, 4);
                queue_word(REQ_START, MELODY_W'(m));
                while (plan.active)
                    queue_ticks(1);
                queue_ticks($urandom_range(0, 3));
            end else if (pick < 75) begin
                queue_word(REQ_START, MELODY_W'($urandom_range(0, 7)));
                queue_ticks(($urandom_range(0, 3) == 0) ? $urandom_range(90, 320)
                                                        : $urandom_range(1, 20));
                if ($urandom_range(0, 2) == 0)
                    queue_word(REQ_STOP, MELODY_W'($urandom_range(0, 7)));
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_word(2'($urandom_range(0, 3)), MELODY_W'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 19) == 0)
                drain_next = 1'b1;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d request words, %0d tones or rests loaded, %0d melodies played out.",
                 n_sent, n_loaded, n_finished);
        $display("Checked %0d result words under random stalls on both sides.", n_results);
        if (n_errors == 0) begin
            $display("[tone_melody_sequencer] OK");
        end else begin
            $display("[tone_melody_sequencer] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("[tone_melody_sequencer] ERROR");
        $finish;
    end

endmodule
